// ===== rtl/lkv_pkg.sv =====
// Package for the LRU key-value cache: request and response payload types,
// operation codes and fixed field widths. No dependencies.
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
    } rsp_t;

endpackage

// ===== rtl/lkv_entry_array.sv =====
// Entry storage of the LRU key-value cache: keys, values, valid bits and age
// ranks, with the parallel lookup and the LRU age-rank update. Uses lkv_pkg.
module lkv_entry_array #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  lkv_pkg::req_t              req,
    input  logic [lkv_pkg::CAP_W-1:0]  capacity,
    output lkv_pkg::rsp_t              rsp
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [KEY_W-1:0]        key_reg  [ENTRIES];
    logic signed [VAL_W-1:0] val_reg  [ENTRIES];
    logic [RANK_W-1:0]       rank_reg [ENTRIES];
    logic [RANK_W-1:0]       rank_next[ENTRIES];
    logic [ENTRIES-1:0]      valid_reg;
    logic [ENTRIES-1:0]      valid_next;
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;

    logic [ENTRIES-1:0]      match;
    logic                    hit;
    logic [RANK_W-1:0]       hit_rank;
    logic signed [VAL_W-1:0] hit_value;
    logic [CMP_W-1:0]        cap_lim;
    logic                    full;
    logic [RANK_W-1:0]       oldest_rank;
    logic [ENTRIES-1:0]      evict_oh;
    logic [ENTRIES-1:0]      free_vec;
    logic [ENTRIES-1:0]      fill_oh;
    logic [ENTRIES-1:0]      key_we;
    logic [ENTRIES-1:0]      val_we;
    logic                    is_set;

    assign is_set = (req.func == FUNC_SET);

    // Parallel key compare; at most one valid entry holds a given key
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | val_reg[i];
            end
        end
    end

    assign hit = |match;

    // Effective capacity: zero acts as one, clipped at the entry count
    always_comb
    begin
        priority if (capacity == '0)
            cap_lim = CMP_W'(1);
        else if (CMP_W'(capacity) > CMP_W'(ENTRIES))
            cap_lim = CMP_W'(ENTRIES);
        else
            cap_lim = CMP_W'(capacity);
    end

    assign full        = CMP_W'(occ_reg) >= cap_lim;
    assign oldest_rank = RANK_W'(occ_reg - CNT_W'(1));

    // Victim is the valid entry holding the highest rank
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
            evict_oh[i] = full && valid_reg[i] && (rank_reg[i] == oldest_rank);
    end

    // Lowest free entry after the eviction
    assign free_vec = ~valid_reg | evict_oh;
    assign fill_oh  = free_vec & (~free_vec + ENTRIES'(1));

    // Next state of valid bits, ranks and occupancy
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        key_we     = '0;
        val_we     = '0;
        for (int i = 0; i < ENTRIES; i++)
            rank_next[i] = rank_reg[i];
        if (fire)
        begin
            if (hit)
            begin
                // Touch: younger entries age by one, hit entry becomes newest
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match[i])
                        rank_next[i] = '0;
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
                if (is_set)
                    val_we = match;
            end
            else if (is_set)
            begin
                // Fill with optional eviction; every survivor ages by one
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (fill_oh[i])
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (evict_oh[i])
                    begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
                key_we = fill_oh;
                val_we = fill_oh;
                if (!full)
                    occ_next = occ_reg + CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // Key and value storage, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (key_we[i])
                key_reg[i] <= req.key;
            if (val_we[i])
                val_reg[i] <= req.value;
        end
    end

    assign rsp.hit        = hit;
    assign rsp.read_value = hit_value;

    // Occupancy tracks the valid bits
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy count out of step with valid bits");

    // Never more entries in use than exist
    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= ENTRIES)
        else $error("occupancy above entry count");

    // A key is held by at most one valid entry
    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    // A fill evicts at most one entry and always finds a free slot
    a_fill_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_set && !hit) |-> ($onehot0(evict_oh) && (fill_oh != '0)))
        else $error("fill without a free entry");

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// Top level of the LRU key-value cache. Uses lkv_pkg and lkv_entry_array.
//
// Usage:
//   Requests enter on req/req_valid and are accepted at a clock edge with
//   req_valid high and req_stall low. A get (func 0) yields one response on
//   rsp/rsp_valid, taken at an edge with rsp_stall low; a set (func 1)
//   yields none. A get returns hit and the stored value, or hit 0 and zero.
//   Pipeline: a request is registered in the input stage on acceptance and
//   is looked up and applied from there; a get waits there until the output
//   register has room. Its response is loaded into the output register,
//   which drives rsp and rsp_valid.
//   Throughput: one request per cycle while req_stall is low; the key compare
//   across all entries and the next age ranks are computed combinationally.
//   When rsp_stall holds a response, a get waiting behind it blocks the
//   input stage and req_stall rises; sets keep flowing.
//   The capacity register is written on cfg_data when cfg_valid and cfg_ready
//   are high; the user must do so only while no request is in flight, as the
//   block does not enforce it. Reset empties the cache and sets capacity to 16.
module lru_key_value_cache_top #(
    parameter int ENTRIES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  lkv_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output lkv_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]  cfg_data
);
    import lkv_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    req_t               in_req_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_t               out_rsp_reg;
    rsp_t               lookup_rsp;
    logic [CAP_W-1:0]   cap_reg;
    logic               proc;
    logic               accept;
    logic               out_load;
    logic               out_take;

    // Stage handshake: a get needs room in the output register
    assign proc = in_valid_reg &&
                  ((in_req_reg.func == FUNC_SET) || !out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !proc;
    assign accept    = req_valid && !req_stall;
    assign out_take  = out_valid_reg && !rsp_stall;
    assign out_load  = proc && (in_req_reg.func == FUNC_GET);

    assign in_valid_next  = accept || (in_valid_reg && !proc);
    assign out_valid_next = out_load || (out_valid_reg && !out_take);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            in_req_reg <= req;
        if (out_load)
            out_rsp_reg <= lookup_rsp;
    end

    lkv_entry_array #(
        .ENTRIES (ENTRIES)
    ) u_entries (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (proc),
        .req      (in_req_reg),
        .capacity (cap_reg),
        .rsp      (lookup_rsp)
    );

    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule

// ===== test/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// Testbench for lru_key_value_cache_top: get and set requests with random idling,
// each read response checked against a directed value or an LRU predictor. Depends on lkv_pkg and the RTL.
module testbench;
    import lkv_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int PLAN_LEN   = 22;
    localparam int KEY_POOL   = 24;
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 83;

    // One directed request; want is used only when typed is set
    typedef struct {
        logic                    func;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        bit                      typed;
        rsp_t                    want;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_stall;
    rsp_t             rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    // Shadow copy of the cache
    logic [KEY_W-1:0]        shadow_key   [ENTRIES];
    logic signed [VAL_W-1:0] shadow_value [ENTRIES];
    bit                      shadow_valid [ENTRIES];
    int unsigned             shadow_rank  [ENTRIES];
    int unsigned             shadow_count;
    logic [CAP_W-1:0]        shadow_capacity;

    rsp_t      expected_reads[$];
    plan_row_t plan [PLAN_LEN];
    bit        idle_off;
    int        fail_count;
    int        req_count;
    int        get_count;
    int        hit_count;
    int        rsp_count;
    int        cfg_count;

    lru_key_value_cache_top #(.ENTRIES(ENTRIES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int find_entry(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_key[i] == k)
                return i;
        return -1;
    endfunction

    // Entry idx becomes most recent; younger valid entries age by one
    function automatic void make_recent(int idx);
        int unsigned r;
        r = shadow_rank[idx];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && i != idx && shadow_rank[i] < r)
                shadow_rank[i]++;
        shadow_rank[idx] = 0;
    endfunction

    // Apply one request to the shadow cache; a get yields the read it should return
    function automatic void lru_predict(input req_t r, output rsp_t read, output bit is_read);
        int          idx;
        int          slot;
        int unsigned limit;
        limit = (shadow_capacity == 0) ? 1 :
                ((shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity);
        idx     = find_entry(r.key);
        is_read = (r.func == FUNC_GET);
        read    = '0;
        if (is_read)
        begin
            if (idx >= 0)
            begin
                read.hit        = 1'b1;
                read.read_value = shadow_value[idx];
                make_recent(idx);
            end
            return;
        end
        // set of a resident key: overwrite in place
        if (idx >= 0)
        begin
            shadow_value[idx] = r.value;
            make_recent(idx);
            return;
        end
        // at or over capacity: drop the least recent entry (last on ties)
        if (shadow_count >= limit)
        begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (slot < 0 || shadow_rank[i] >= shadow_rank[slot]))
                    slot = i;
            if (slot >= 0)
            begin
                shadow_valid[slot] = 1'b0;
                shadow_rank[slot]  = 0;
                if (shadow_count > 0)
                    shadow_count--;
            end
        end
        // fill the lowest free entry
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (!shadow_valid[i] && slot < 0)
                slot = i;
        if (slot < 0)
            return;
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i])
                shadow_rank[i]++;
        shadow_valid[slot] = 1'b1;
        shadow_key[slot]   = r.key;
        shadow_value[slot] = r.value;
        shadow_rank[slot]  = 0;
        shadow_count++;
    endfunction

    // Drive one request after a random gap; update the shadow when it is taken
    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        int   gap;
        rsp_t predicted;
        bit   is_read;
        @(negedge clk);
        gap = idle_off ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        do @(posedge clk); while (req_stall);
        lru_predict(r, predicted, is_read);
        req_count++;
        if (is_read)
        begin
            get_count++;
            expected_reads.push_back(typed ? want : predicted);
        end
    endtask

    // Capacity write once the cache has drained
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        req_valid = 1'b0;
        while (expected_reads.size() != 0) @(posedge clk);
        // trailing sets give no response; let them retire
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = cap;
        do @(posedge clk); while (!cfg_ready);
        shadow_capacity = cap;
        cfg_count++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Response side: random stall before each response
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = idle_off ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                rsp_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall = 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Response check against the oldest expected read
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, actual hit=%0b value=%0d",
                         $time, rsp.hit, rsp.read_value);
                fail_count++;
            end
            else
            begin
                want = expected_reads.pop_front();
                rsp_count++;
                if (rsp.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch: expected %0b, actual %0b",
                             $time, want.hit, rsp.hit);
                    fail_count++;
                end
                if (rsp.read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %0d, actual %0d",
                             $time, want.read_value, rsp.read_value);
                    fail_count++;
                end
                if (rsp.hit === 1'b1)
                    hit_count++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d reads outstanding", expected_reads.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] key_pool   [KEY_POOL];
        logic [CAP_W-1:0] phase_caps [PHASES];
        req_t             r;
        int               pool_size;

        req_valid  = 1'b0;
        req        = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        idle_off   = 1'b0;
        fail_count = 0;
        req_count  = 0;
        get_count  = 0;
        hit_count  = 0;
        rsp_count  = 0;
        cfg_count  = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
        end
        shadow_count    = 0;
        shadow_capacity = CAP_RESET;

        // Directed requests at the reset capacity
        plan = '{
            '{FUNC_GET, 32'h0000_0000, 32'sh0000_0000, 1'b1, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, '{1'b0, 32'sh0000_0000}},
            '{FUNC_SET, 32'h0000_0000, 32'sh7FFF_FFFF, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_SET, 32'hFFFF_FFFF, 32'sh8000_0000, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0000, 32'sh0000_0000, 1'b1, '{1'b1, 32'sh7FFF_FFFF}},
            '{FUNC_GET, 32'hFFFF_FFFF, 32'sh0000_0000, 1'b1, '{1'b1, 32'sh8000_0000}},
            '{FUNC_SET, 32'h0000_0000, 32'shFFFF_FFFF, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0000, 32'sh0000_0000, 1'b1, '{1'b1, 32'shFFFF_FFFF}},
            '{FUNC_GET, 32'h1234_5678, 32'sh0000_0000, 1'b1, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'hFFFF_FFFF, 32'sh5A5A_5A5A, 1'b1, '{1'b1, 32'sh8000_0000}},
            '{FUNC_SET, 32'h0000_0001, 32'sh0000_0000, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_SET, 32'h0000_0002, 32'sh0000_0001, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_SET, 32'h0000_0003, 32'sh5555_5555, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_SET, 32'h0000_0004, 32'shAAAA_AAAA, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0003, 32'sh0000_0000, 1'b1, '{1'b1, 32'sh5555_5555}},
            '{FUNC_SET, 32'h0000_0001, 32'sh0000_0002, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0001, 32'sh0000_0000, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0002, 32'sh0000_0000, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0004, 32'sh0000_0000, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'h0000_0005, 32'sh0000_0000, 1'b1, '{1'b0, 32'sh0000_0000}},
            '{FUNC_SET, 32'hFFFF_FFFE, 32'sh1234_5678, 1'b0, '{1'b0, 32'sh0000_0000}},
            '{FUNC_GET, 32'hFFFF_FFFE, 32'sh0000_0000, 1'b0, '{1'b0, 32'sh0000_0000}}
        };

        // Capacities per phase: minimum, zero, all ones, full, shrink below fill, etc.
        phase_caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd2, 5'd8, 5'd16, 5'd4};

        // Keys shared across phases so entries survive capacity changes
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            r.func  = plan[i].func;
            r.key   = plan[i].key;
            r.value = plan[i].value;
            send_request(r, plan[i].typed, plan[i].want);
        end

        // Random phases: keys mostly from a pool a little larger than the capacity, at most KEY_POOL keys
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_caps[p]);
            idle_off  = (p % 4 == 2);
            pool_size = phase_caps[p] + $urandom_range(1, 4);
            if (pool_size > KEY_POOL)
                pool_size = KEY_POOL;
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                r.func  = $urandom_range(0, 1) ? FUNC_SET : FUNC_GET;
                r.key   = ($urandom_range(0, 99) < 12) ? $urandom
                                                       : key_pool[$urandom_range(0, pool_size - 1)];
                r.value = $urandom;
                send_request(r, 1'b0, '0);
            end
        end

        @(negedge clk);
        req_valid = 1'b0;
        idle_off  = 1'b0;
        while (expected_reads.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d requests (%0d gets, %0d hits) across %0d capacity settings",
                 req_count, get_count, hit_count, cfg_count);
        $display("%0d read responses compared, %0d mismatches", rsp_count, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== lru_key_value_cache_top.f =====
rtl/lkv_pkg.sv
rtl/lkv_entry_array.sv
rtl/lru_key_value_cache_top.sv
test/lru_key_value_cache_tb.sv
